[rtl/assert_macros.svh]
// assertion macros used by the checker file adfp_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is active
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion, checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/adfp_pkg.sv]
// package for the ascii decimal to fixed-point parser
// widths, character codes, fraction weights and shared structs; no dependencies
`default_nettype none

package adfp_pkg;

  // number format
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned INT_BITS        = 32;
  localparam int unsigned MAX_FRAC_DIGITS = 5;

  localparam int unsigned OUT_W  = INT_BITS + FRAC_BITS;
  localparam int unsigned ACC_W  = INT_BITS - 1;
  localparam int unsigned FSUM_W = FRAC_BITS + 1;
  localparam int unsigned FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int unsigned CNT_W  = 20;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DELIM = 2'd0;
  localparam logic [IDX_W-1:0] REG_LIMIT = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMODE = 2'd2;

  // register reset values
  localparam logic [7:0]       DELIM_RST = 8'd10;
  localparam logic [CNT_W-1:0] LIMIT_RST = 20'd500000;

  // character codes
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_POINT = 8'd46;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // round(2^FRAC_BITS / 10^k)
  localparam int unsigned W1 = ((2 ** (FRAC_BITS + 1)) / 10 + 1) / 2;
  localparam int unsigned W2 = ((2 ** (FRAC_BITS + 1)) / 100 + 1) / 2;
  localparam int unsigned W3 = ((2 ** (FRAC_BITS + 1)) / 1000 + 1) / 2;
  localparam int unsigned W4 = ((2 ** (FRAC_BITS + 1)) / 10000 + 1) / 2;
  localparam int unsigned W5 = ((2 ** (FRAC_BITS + 1)) / 100000 + 1) / 2;
  localparam int unsigned W6 = ((2 ** (FRAC_BITS + 1)) / 1000000 + 1) / 2;
  localparam int unsigned W7 = ((2 ** (FRAC_BITS + 1)) / 10000000 + 1) / 2;

  function automatic logic [FSUM_W-1:0] frac_weight(input logic [2:0] k);
    logic [FSUM_W-1:0] w;
    case (k)
      3'd1:    w = FSUM_W'(W1);
      3'd2:    w = FSUM_W'(W2);
      3'd3:    w = FSUM_W'(W3);
      3'd4:    w = FSUM_W'(W4);
      3'd5:    w = FSUM_W'(W5);
      3'd6:    w = FSUM_W'(W6);
      3'd7:    w = FSUM_W'(W7);
      default: w = '0;
    endcase
    return w;
  endfunction

  // configuration seen by the datapath
  typedef struct packed {
    logic [7:0]       delim;
    logic [CNT_W-1:0] limit;
    logic             imode;
  } cfg_t;

  // parse state carried between words
  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [FSUM_W-1:0] fsum;
    logic [FCNT_W-1:0] fcnt;
    logic              in_frac;
    logic              neg;
    logic [CNT_W-1:0]  rcnt;
  } state_t;

  // result of one step
  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] value;
    logic                    timed_out;
  } res_t;

endpackage

`default_nettype wire

[rtl/adfp_cfg.sv]
// configuration registers of the parser
// depends on adfp_pkg
`default_nettype none

module adfp_cfg
  import adfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // indexed writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim <= DELIM_RST;
      cfg_q.limit <= LIMIT_RST;
      cfg_q.imode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELIM: cfg_q.delim <= cfg_wdata_i[7:0];
        REG_LIMIT: cfg_q.limit <= cfg_wdata_i[CNT_W-1:0];
        REG_IMODE: cfg_q.imode <= cfg_wdata_i[0];
        default:   cfg_q       <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/adfp_step.sv]
// one parse step: next state and optional result for one read
// depends on adfp_pkg
`default_nettype none

module adfp_step
  import adfp_pkg::*;
(
  input  wire cfg_t        cfg_i,
  input  wire state_t      state_i,
  input  wire logic        present_i,
  input  wire logic [7:0]  byte_i,
  output state_t           state_o,
  output res_t             res_o
);

  logic [7:0]        dbyte;
  logic [3:0]        digit;
  logic              is_digit;
  logic [ACC_W+3:0]  acc_ext;
  logic [ACC_W+3:0]  acc_nxt;
  logic [FCNT_W-1:0] fcnt_nxt;
  logic [FSUM_W+3:0] fprod;
  logic [OUT_W-1:0]  mag;
  logic [OUT_W-1:0]  mag_sat;
  logic [OUT_W-1:0]  mag_signed;
  logic [CNT_W-1:0]  rcnt_inc;

  // digit decode
  assign dbyte    = byte_i - CHAR_ZERO;
  assign digit    = dbyte[3:0];
  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);

  // integer accumulate, times ten as two shifts
  assign acc_ext = {4'b0, state_i.acc};
  assign acc_nxt = (acc_ext << 3) + (acc_ext << 1) + (ACC_W + 4)'(digit);

  // fraction term for the next digit position
  assign fcnt_nxt = state_i.fcnt + FCNT_W'(1);
  assign fprod    = (FSUM_W + 4)'(digit) * (FSUM_W + 4)'(frac_weight(3'(fcnt_nxt)));

  // assembled magnitude, saturated, then signed
  always_comb begin
    mag = {1'b0, state_i.acc, FRAC_BITS'(0)};
    if (!cfg_i.imode) begin
      mag = mag + OUT_W'(state_i.fsum);
    end
    mag_sat    = mag[OUT_W-1] ? {1'b0, {(OUT_W - 1){1'b1}}} : mag;
    mag_signed = (state_i.neg && !cfg_i.imode) ? (~mag_sat + OUT_W'(1)) : mag_sat;
  end

  assign rcnt_inc = (&state_i.rcnt) ? state_i.rcnt : state_i.rcnt + CNT_W'(1);

  // step decision
  always_comb begin
    state_o         = state_i;
    res_o.valid     = 1'b0;
    res_o.value     = '0;
    res_o.timed_out = 1'b0;
    if (state_i.rcnt > cfg_i.limit) begin
      res_o.valid     = 1'b1;
      res_o.timed_out = 1'b1;
      state_o         = '0;
    end else if (present_i && (byte_i == cfg_i.delim)) begin
      res_o.valid = 1'b1;
      res_o.value = mag_signed;
      state_o     = '0;
    end else begin
      if (present_i) begin
        if (!cfg_i.imode && (byte_i == CHAR_MINUS)) begin
          state_o.neg = 1'b1;
        end else if (!cfg_i.imode && (byte_i == CHAR_POINT)) begin
          state_o.in_frac = 1'b1;
        end else if (is_digit) begin
          if (cfg_i.imode || !state_i.in_frac) begin
            state_o.acc = (|acc_nxt[ACC_W+3:ACC_W]) ? {ACC_W{1'b1}} : acc_nxt[ACC_W-1:0];
          end else if (state_i.fcnt < FCNT_W'(MAX_FRAC_DIGITS)) begin
            state_o.fcnt = fcnt_nxt;
            state_o.fsum = state_i.fsum + fprod[FSUM_W-1:0];
          end
        end
      end
      state_o.rcnt = rcnt_inc;
    end
  end

endmodule

`default_nettype wire

[rtl/ascii_decimal_to_fixed_parser.sv]
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_ready_o   byte_present_i, rx_byte_i
// out       out  out_valid_o / out_ready_i parsed_value_o, timed_out_o
// cfg       in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one word per cycle sustained while no result is stalled; a word goes into
// the input register, then through one step of logic into the result register
// reset clears the parse state, the registers to their defaults, both stages
// a waiting result stalls only words that produce a result; empty reads and
// digits keep flowing past a stalled output
`default_nettype none

module ascii_decimal_to_fixed_parser
  import adfp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [IDX_W-1:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    byte_present_i,
  input  wire logic [7:0]              rx_byte_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [OUT_W-1:0]      parsed_value_o,
  output logic                         timed_out_o
);

  cfg_t   cfg;
  state_t state_q, state_d;
  res_t   res;

  logic                    in_valid_q;
  logic                    present_q;
  logic [7:0]              byte_q;
  logic                    advance;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] value_q;
  logic                    timed_out_q;

  adfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  adfp_step u_step (
    .cfg_i     (cfg),
    .state_i   (state_q),
    .present_i (present_q),
    .byte_i    (byte_q),
    .state_o   (state_d),
    .res_o     (res)
  );

  // step fires unless its result would land on a full, stalled output
  assign advance    = in_valid_q && (!res.valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      present_q <= byte_present_i;
      byte_q    <= rx_byte_i;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      value_q     <= res.value;
      timed_out_q <= res.timed_out;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parsed_value_o = value_q;
  assign timed_out_o    = timed_out_q;

endmodule

`default_nettype wire

[rtl/adfp_checker.sv]
// port-level checks for the parser, bound to the top level
// depends on adfp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module adfp_checker
  import adfp_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic signed [OUT_W-1:0] parsed_value_o,
  input wire logic                    timed_out_o
);

  // a stalled result word holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni,
              out_valid_o && !out_ready_i |=>
                out_valid_o && $stable(parsed_value_o) && $stable(timed_out_o),
              "result word changed while stalled")

  // a timeout word carries a zero value
  `ASSERT_RST(a_timeout_zero, clk_i, rst_ni,
              out_valid_o && timed_out_o |-> parsed_value_o == '0,
              "timeout word with nonzero value")

  // input only stalls behind a stalled result
  `ASSERT_RST(a_stall_cause, clk_i, rst_ni,
              !in_ready_o |-> out_valid_o && !out_ready_i,
              "input stalled without output stall")

  // no result word while in reset
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind ascii_decimal_to_fixed_parser adfp_checker u_adfp_checker (.*);

`default_nettype wire
